### hw/rtl/assert_macros.svh
// Clocked assertion helpers; every use site provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define TMCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define TMCW_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hw/rtl/tmcw_pkg.sv
package tmcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CURSOR_W   = 11;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int NIBBLE_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = NIBBLE_W;

  localparam logic [NIBBLE_W-1:0] FG_RESET = 4'd7;
  localparam logic [NIBBLE_W-1:0] BG_RESET = 4'd0;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRINT  = 2'd0,
    CMD_SETPOS = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_PRINT,
    ST_BKSP,
    ST_READ,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attribute;
  } res_t;

endpackage

### hw/rtl/tmcw_in_if.sv
interface tmcw_in_if;
  import tmcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;

  modport source(output valid, output command, output char_code, output column,
                 output row, input ready);
  modport sink(input valid, input command, input char_code, input column,
               input row, output ready);
endinterface

### hw/rtl/tmcw_out_if.sv
interface tmcw_out_if;
  import tmcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_cell;
  logic [CHAR_W-1:0]   cell_char;
  logic [ATTR_W-1:0]   cell_attribute;

  modport source(output valid, output cursor_cell, output cell_char,
                 output cell_attribute, input ready);
  modport sink(input valid, input cursor_cell, input cell_char,
               input cell_attribute, output ready);
endinterface

### hw/rtl/tmcw_screen_ram.sv
module tmcw_screen_ram #(
  parameter int DEPTH  = tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [tmcw_pkg::CELL_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [tmcw_pkg::CELL_W-1:0] rd_data
);
  import tmcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/tmcw_ctrl.sv
`include "assert_macros.svh"

module tmcw_ctrl #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int ADDR_W  = $clog2(CELLS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tmcw_in_if.sink                     in_bus,
  input  logic [tmcw_pkg::ATTR_W-1:0] attr,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tmcw_pkg::res_t              res,
  output logic                        ram_wr_en,
  output logic [ADDR_W-1:0]           ram_wr_addr,
  output logic [tmcw_pkg::CELL_W-1:0] ram_wr_data,
  output logic                        ram_rd_en,
  output logic [ADDR_W-1:0]           ram_rd_addr,
  input  logic [tmcw_pkg::CELL_W-1:0] ram_rd_data
);
  import tmcw_pkg::*;

  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int CCOL_W = $clog2(COLUMNS);
  localparam int CROW_W = $clog2(ROWS);
  localparam int KEEP   = CELLS - COLUMNS;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CCOL_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]    cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic [ATTR_W-1:0]   fill_r, fill_nxt;
  logic                res_valid_r, res_valid_nxt;
  res_t                res_r, res_nxt;

  logic                accept;
  logic                pos_past_end;
  logic [CCOL_W-1:0]   cl_col;
  logic [CROW_W-1:0]   cl_row;
  logic [ADDR_W-1:0]   cl_addr;
  logic [CHAR_W-1:0]   ch_sel;
  logic                pa_bksp;
  logic                pa_bksp_home;
  logic                pa_newline;
  logic [POS_W-1:0]    pos_dec;
  logic [CCOL_W-1:0]   col_inc;
  logic [CCOL_W-1:0]   col_dec;

  assign in_bus.ready = (state_r == ST_IDLE) && (!res_valid_r || res_ready);
  assign accept       = in_bus.valid && in_bus.ready;
  assign res_valid    = res_valid_r;
  assign res          = res_r;
  assign pos_past_end = pos_r >= POS_W'(CELLS);

  // Saturate the requested column and row to the screen.
  always_comb begin
    if (32'(in_bus.column) > COLUMNS - 1) begin
      cl_col = CCOL_W'(COLUMNS - 1);
    end else begin
      cl_col = CCOL_W'(in_bus.column);
    end
    if (32'(in_bus.row) > ROWS - 1) begin
      cl_row = CROW_W'(ROWS - 1);
    end else begin
      cl_row = CROW_W'(in_bus.row);
    end
    cl_addr = ADDR_W'(32'(cl_row) * COLUMNS) + ADDR_W'(cl_col);
  end

  // Character decode shared by a fresh print and a print after a scroll.
  always_comb begin
    ch_sel       = (state_r == ST_PRINT) ? char_r : in_bus.char_code;
    pa_bksp      = (ch_sel == CH_BACKSPACE) && (pos_r != '0);
    pa_bksp_home = (ch_sel == CH_BACKSPACE) && (pos_r == '0);
    pa_newline   = (ch_sel == CH_NEWLINE);
    pos_dec      = pos_r - POS_W'(1);
    col_inc      = (32'(col_r) == COLUMNS - 1) ? '0 : col_r + CCOL_W'(1);
    col_dec      = (col_r == '0) ? CCOL_W'(COLUMNS - 1) : col_r - CCOL_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (cnt_r == POS_W'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_bus.command))
            CMD_PRINT: begin
              if (pos_past_end)  state_nxt = ST_SCROLL;
              else if (pa_bksp) state_nxt = ST_BKSP;
            end
            CMD_SETPOS: state_nxt = ST_IDLE;
            CMD_CLEAR:  state_nxt = ST_CLEAR;
            CMD_READ:   state_nxt = ST_READ;
          endcase
        end
      end
      ST_SCROLL: begin
        if (cnt_r == POS_W'(CELLS)) state_nxt = ST_PRINT;
      end
      ST_PRINT: begin
        state_nxt = pa_bksp ? ST_BKSP : ST_IDLE;
      end
      ST_BKSP, ST_READ: state_nxt = ST_IDLE;
      ST_CLEAR: begin
        if (cnt_r == POS_W'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    logic do_print;

    do_print      = 1'b0;
    pos_nxt       = pos_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    char_nxt      = char_r;
    fill_nxt      = fill_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = ADDR_W'(pos_r);
    ram_wr_data   = {attr, ch_sel};
    ram_rd_en     = 1'b0;
    ram_rd_addr   = ADDR_W'(pos_dec);

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = ADDR_W'(cnt_r);
        ram_wr_data = (state_r == ST_CLEAR) ? {fill_r, CH_BLANK} : '0;
        cnt_nxt     = cnt_r + POS_W'(1);
        if (cnt_r == POS_W'(CELLS - 1)) begin
          cnt_nxt = '0;
          if (state_r == ST_CLEAR) begin
            pos_nxt       = '0;
            col_nxt       = '0;
            res_valid_nxt = 1'b1;
            res_nxt       = '{cursor_cell: '0, cell_char: '0, cell_attribute: '0};
          end
        end
      end
      ST_IDLE: begin
        if (accept) begin
          char_nxt = in_bus.char_code;
          unique case (cmd_t'(in_bus.command))
            CMD_PRINT: do_print = !pos_past_end;
            CMD_SETPOS: begin
              pos_nxt       = POS_W'(cl_addr);
              col_nxt       = cl_col;
              res_valid_nxt = 1'b1;
              res_nxt       = '{cursor_cell: CURSOR_W'(cl_addr), cell_char: '0,
                                cell_attribute: '0};
            end
            CMD_CLEAR: fill_nxt = attr;
            CMD_READ: begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = cl_addr;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // Read one row ahead, write the word that came back one cell behind.
        if (cnt_r < POS_W'(KEEP)) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ADDR_W'(cnt_r + POS_W'(COLUMNS));
        end
        if (cnt_r != '0) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ADDR_W'(cnt_r - POS_W'(1));
          ram_wr_data = (cnt_r <= POS_W'(KEEP)) ? ram_rd_data : '0;
        end
        cnt_nxt = cnt_r + POS_W'(1);
        if (cnt_r == POS_W'(CELLS)) begin
          cnt_nxt = '0;
          pos_nxt = POS_W'(KEEP);
          col_nxt = '0;
        end
      end
      ST_PRINT: do_print = 1'b1;
      ST_BKSP: begin
        // Keep the attribute, blank the character.
        ram_wr_en     = 1'b1;
        ram_wr_addr   = ADDR_W'(pos_dec);
        ram_wr_data   = {ram_rd_data[CELL_W-1:CHAR_W], CH_BLANK};
        pos_nxt       = pos_dec;
        col_nxt       = col_dec;
        res_valid_nxt = 1'b1;
        res_nxt       = '{cursor_cell: CURSOR_W'(pos_dec), cell_char: '0,
                          cell_attribute: '0};
      end
      ST_READ: begin
        res_valid_nxt = 1'b1;
        res_nxt       = '{cursor_cell: CURSOR_W'(pos_r),
                          cell_char: ram_rd_data[CHAR_W-1:0],
                          cell_attribute: ram_rd_data[CELL_W-1:CHAR_W]};
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase

    if (do_print) begin
      if (pa_bksp) begin
        ram_rd_en = 1'b1;
      end else if (pa_bksp_home) begin
        res_valid_nxt = 1'b1;
        res_nxt       = '{cursor_cell: '0, cell_char: '0, cell_attribute: '0};
      end else if (pa_newline) begin
        pos_nxt       = pos_r + POS_W'(COLUMNS) - POS_W'(col_r);
        col_nxt       = '0;
        res_valid_nxt = 1'b1;
        res_nxt       = '{cursor_cell: CURSOR_W'(pos_nxt), cell_char: '0,
                          cell_attribute: '0};
      end else begin
        ram_wr_en     = 1'b1;
        pos_nxt       = pos_r + POS_W'(1);
        col_nxt       = col_inc;
        res_valid_nxt = 1'b1;
        res_nxt       = '{cursor_cell: CURSOR_W'(pos_nxt), cell_char: '0,
                          cell_attribute: '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      pos_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    fill_r <= fill_nxt;
    res_r  <= res_nxt;
  end

  `TMCW_NEVER(a_rw_same_cell, ram_rd_en && ram_wr_en && (ram_rd_addr == ram_wr_addr), "read and write hit the same cell")
  `TMCW_NEVER(a_pos_range, pos_r > POS_W'(CELLS), "write position past screen end")
  `TMCW_NEVER(a_col_range, 32'(col_r) >= COLUMNS, "column tracker out of range")
  `TMCW_ASSERT(a_res_hold, res_valid_r && !res_ready |=> res_valid_r && $stable(res_r), "pending result lost")
  `TMCW_NEVER(a_busy_accept, in_bus.ready && (cnt_r != '0), "input taken during a sweep")

endmodule

### hw/rtl/text_mode_console_writer_unit.sv
// Channel  | dir | beat payload                                 | handshake
// ---------+-----+----------------------------------------------+-----------
// in_bus   | in  | command, char_code, column, row              | valid/ready
// out_bus  | out | cursor_cell, cell_char, cell_attribute       | valid/ready
// cfg_*    | in  | cfg_index selects fg/bg colour, cfg_wdata    | cfg_we only
//
// Set position, newline, an ordinary character and backspace at cell 0 finish in their
// accept cycle. Backspace and read cell add a second state (ST_BKSP, ST_READ): the
// screen memory read is registered, so data returns in the cycle after the address.
// Clear, after its accept cycle, writes one cell per cycle through the single write
// port. A print past the screen end first scrolls up a row in ST_SCROLL (one cell moved
// per cycle), then prints in ST_PRINT, and a backspace goes on through ST_BKSP.
// After reset a clearing pass zeroes all COLUMNS*ROWS cells (2000 by default) of the
// screen; no beat is accepted meanwhile, configuration writes are taken.
// A result register and the output register decouple the sides: one result may
// wait while the next beat is accepted.
module text_mode_console_writer_unit #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tmcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmcw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tmcw_in_if.sink                         in_bus,
  tmcw_out_if.source                      out_bus
);
  import tmcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [NIBBLE_W-1:0] fg_r;
  logic [NIBBLE_W-1:0] bg_r;

  logic                res_valid;
  logic                res_ready;
  res_t                res;
  logic                out_valid_r;
  res_t                out_r;

  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic [CELL_W-1:0]   ram_wr_data;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [CELL_W-1:0]   ram_rd_data;

  // Colour registers; write them only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FG: fg_r <= cfg_wdata;
        CFG_BG: bg_r <= cfg_wdata;
      endcase
    end
  end

  tmcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tmcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .attr        ({bg_r, fg_r}),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Output register: advance a result when the slot is empty or being drained.
  assign res_ready = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.cursor_cell    = out_r.cursor_cell;
  assign out_bus.cell_char      = out_r.cell_char;
  assign out_bus.cell_attribute = out_r.cell_attribute;

endmodule

### verif/text_mode_console_writer_unit_tb.sv
`timescale 1ns / 1ps

module text_mode_console_writer_unit_tb;
  import tmcw_pkg::*;

  localparam int COLS         = COLUMNS_DEF;
  localparam int LINES        = ROWS_DEF;
  localparam int SCREEN_CELLS = COLS * LINES;
  // The slowest beat is a scroll followed by a backspace.
  // Allow that for every beat, with the stalls on top, several times over.
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int PHASE_ITEMS  = 400;
  localparam int PHASE_SETTLE = 16;
  // A clear or scroll walks the whole screen, so wait out that much at the end.
  localparam int END_SETTLE   = SCREEN_CELLS + 100;

  // Shadow copy of the console: screen, cursor and colours, plus the queue
  // of results that the block still owes.
  class console_shadow;
    logic [CELL_W-1:0]   screen [SCREEN_CELLS];
    int unsigned         cursor;
    logic [NIBBLE_W-1:0] fg_colour;
    logic [NIBBLE_W-1:0] bg_colour;
    res_t                owed_results [$];
    int unsigned         n_errors;
    int unsigned         n_checked;
    int unsigned         n_scrolls;
    int unsigned         n_by_cmd [4];

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor    = 0;
      fg_colour = FG_RESET;
      bg_colour = BG_RESET;
      n_errors  = 0;
      n_checked = 0;
      n_scrolls = 0;
      foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
    endfunction

    function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FG) fg_colour = data;
      else if (idx == CFG_BG) bg_colour = data;
    endfunction

    function int unsigned clamp_index(logic [COL_W-1:0] col, logic [ROW_W-1:0] rw);
      int unsigned c;
      int unsigned r;
      c = (col > COLS - 1) ? COLS - 1 : col;
      r = (rw > LINES - 1) ? LINES - 1 : rw;
      return r * COLS + c;
    endfunction

    // Apply one accepted command beat and queue the result it must produce.
    function void note_command(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] rw);
      res_t              res;
      logic [CELL_W-1:0] word;
      logic [ATTR_W-1:0] attr;
      attr = {bg_colour, fg_colour};
      res  = '0;
      n_by_cmd[cmd]++;
      case (cmd)
        CMD_PRINT: begin
          if (cursor >= SCREEN_CELLS) begin
            for (int i = 0; i < SCREEN_CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = SCREEN_CELLS - COLS; i < SCREEN_CELLS; i++) screen[i] = '0;
            cursor = SCREEN_CELLS - COLS;
            n_scrolls++;
          end
          if (ch == CH_BACKSPACE) begin
            if (cursor > 0) begin
              cursor--;
              screen[cursor][CHAR_W-1:0] = CH_BLANK;
            end
          end else if (ch == CH_NEWLINE) begin
            cursor += COLS - (cursor % COLS);
          end else begin
            screen[cursor] = {attr, ch};
            cursor++;
          end
        end
        CMD_SETPOS: cursor = clamp_index(col, rw);
        CMD_CLEAR: begin
          foreach (screen[i]) screen[i] = {attr, CH_BLANK};
          cursor = 0;
        end
        default: begin
          word               = screen[clamp_index(col, rw)];
          res.cell_char      = word[CHAR_W-1:0];
          res.cell_attribute = word[CELL_W-1:CHAR_W];
        end
      endcase
      res.cursor_cell = cursor[CURSOR_W-1:0];
      owed_results.push_back(res);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        $error("result beat with nothing owed: cursor_cell=%0d cell_char=%0d cell_attribute=%0d",
               got.cursor_cell, got.cell_char, got.cell_attribute);
        n_errors++;
        return;
      end
      want = owed_results.pop_front();
      n_checked++;
      if (got.cursor_cell !== want.cursor_cell) begin
        $error("cursor_cell: expected %0d, actual %0d", want.cursor_cell, got.cursor_cell);
        n_errors++;
      end
      if (got.cell_char !== want.cell_char) begin
        $error("cell_char: expected 0x%02h, actual 0x%02h", want.cell_char, got.cell_char);
        n_errors++;
      end
      if (got.cell_attribute !== want.cell_attribute) begin
        $error("cell_attribute: expected 0x%02h, actual 0x%02h",
               want.cell_attribute, got.cell_attribute);
        n_errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tmcw_in_if  in_bus ();
  tmcw_out_if out_bus ();

  text_mode_console_writer_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  console_shadow shadow = new();

  // Percent of cycles the command side idles and the result side stalls.
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  longint      cycle_count = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result side: toggle ready at random, check every beat taken.
  always @(posedge clk) begin
    res_t got;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.cursor_cell    = out_bus.cursor_cell;
        got.cell_char      = out_bus.cell_char;
        got.cell_attribute = out_bus.cell_attribute;
        shadow.check_result(got);
      end
      out_bus.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still owed",
             cycle_count, shadow.owed_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Write one colour register; call only while the block is idle (not checked here).
  task automatic write_colour(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.set_colour(idx, data);
  endtask

  // Drive one command beat, with random idle cycles ahead of it, and hold
  // it until the block takes it.
  task automatic send_command(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] col,
                              logic [ROW_W-1:0] rw);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.char_code <= ch;
    in_bus.column    <= col;
    in_bus.row       <= rw;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    shadow.note_command(cmd, ch, col, rw);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain(int unsigned settle);
    in_bus.valid <= 1'b0;
    while (shadow.owed_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One random pick. Most picks are runs of text with embedded control codes;
  // cursor moves lean toward the bottom rows so that text runs off the screen
  // and scrolls. Reads and field values may fall out of range.
  task automatic random_pick();
    int unsigned       pick;
    int unsigned       run_len;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  rw;
    pick = $urandom_range(0, 99);
    col  = COL_W'($urandom_range(0, (1 << COL_W) - 1));
    rw   = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
    if (pick < 56) begin
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        ch = CHAR_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          0: ch = CH_NEWLINE;
          1: ch = CH_BACKSPACE;
          default: ;
        endcase
        send_command(CMD_PRINT, ch, COL_W'($urandom_range(0, (1 << COL_W) - 1)),
                     ROW_W'($urandom_range(0, (1 << ROW_W) - 1)));
      end
    end else if (pick < 70) begin
      if ($urandom_range(0, 3) != 0) begin
        col = COL_W'($urandom_range(0, COLS - 1));
        rw  = ROW_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, LINES - 1)
                                                 : $urandom_range(LINES - 2, LINES - 1));
      end
      send_command(CMD_SETPOS, CHAR_W'($urandom_range(0, 255)), col, rw);
    end else if (pick < 97) begin
      if ($urandom_range(0, 4) != 0) begin
        col = COL_W'($urandom_range(0, COLS - 1));
        rw  = ROW_W'($urandom_range(0, LINES - 1));
      end
      send_command(CMD_READ, CHAR_W'($urandom_range(0, 255)), col, rw);
    end else begin
      send_command(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), col, rw);
    end
  endtask

  task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                  int unsigned n_items);
    int unsigned start_count;
    snd_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
    start_count   = shadow.n_checked + shadow.owed_results.size();
    while (shadow.n_checked + shadow.owed_results.size() - start_count < n_items)
      random_pick();
    drain(PHASE_SETTLE);
  endtask

  initial begin
    snd_idle_pct      = 10;
    rcv_stall_pct     = 30;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_FG;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.command   <= CMD_PRINT;
    in_bus.char_code <= '0;
    in_bus.column    <= '0;
    in_bus.row       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Distinct nibbles so a swapped attribute shows up at once.
    write_colour(CFG_FG, 4'd12);
    write_colour(CFG_BG, 4'd3);

    // Directed: reset contents, control codes, saturation, scroll, clear.
    send_command(CMD_READ,   8'd0,          7'd0,   5'd0);   // screen is blank after reset
    send_command(CMD_PRINT,  CH_BACKSPACE,  7'd0,   5'd0);   // backspace at cell zero
    send_command(CMD_PRINT,  8'd65,         7'd127, 5'd31);
    send_command(CMD_PRINT,  8'd0,          7'd0,   5'd0);   // lowest code
    send_command(CMD_PRINT,  8'd255,        7'd0,   5'd0);   // highest code
    send_command(CMD_PRINT,  CH_BACKSPACE,  7'd0,   5'd0);   // blank char, keep attribute
    send_command(CMD_READ,   8'd255,        7'd2,   5'd0);
    send_command(CMD_PRINT,  CH_NEWLINE,    7'd0,   5'd0);   // newline mid-row
    send_command(CMD_PRINT,  CH_NEWLINE,    7'd0,   5'd0);   // newline at a row start
    send_command(CMD_SETPOS, 8'd0,          7'd127, 5'd31);  // saturates to last cell
    send_command(CMD_PRINT,  8'd88,         7'd0,   5'd0);   // cursor now past the end
    send_command(CMD_READ,   8'd0,          7'd127, 5'd31);  // saturated read
    send_command(CMD_PRINT,  8'd66,         7'd0,   5'd0);   // scroll, then print
    send_command(CMD_READ,   8'd0,          7'd79,  5'd23);  // last cell moved up a row
    send_command(CMD_READ,   8'd0,          7'd0,   5'd24);
    send_command(CMD_SETPOS, 8'd0,          7'd79,  5'd24);
    send_command(CMD_PRINT,  CH_NEWLINE,    7'd0,   5'd0);   // runs to the screen end
    send_command(CMD_PRINT,  CH_BACKSPACE,  7'd0,   5'd0);   // scroll, then backspace
    send_command(CMD_SETPOS, 8'd0,          7'd0,   5'd24);
    send_command(CMD_PRINT,  CH_NEWLINE,    7'd0,   5'd0);
    send_command(CMD_PRINT,  CH_NEWLINE,    7'd0,   5'd0);   // scroll, then newline
    send_command(CMD_CLEAR,  8'd0,          7'd0,   5'd0);
    send_command(CMD_READ,   8'd0,          7'd42,  5'd17);  // filled with the attribute
    send_command(CMD_READ,   8'd0,          7'd85,  5'd10);  // column out of range only
    drain(PHASE_SETTLE);

    // Random phases, each with its own colours; both extremes included.
    write_colour(CFG_FG, 4'd15);
    write_colour(CFG_BG, 4'd15);
    run_random_phase(22, 84, PHASE_ITEMS);
    write_colour(CFG_FG, 4'd0);
    write_colour(CFG_BG, 4'd0);
    run_random_phase(84, 22, PHASE_ITEMS);
    write_colour(CFG_FG, 4'd5);
    write_colour(CFG_BG, 4'd10);
    run_random_phase(0, 0, PHASE_ITEMS);

    drain(END_SETTLE);

    $display("Sent %0d prints, %0d cursor moves, %0d clears and %0d reads; %0d scrolls.",
             shadow.n_by_cmd[CMD_PRINT], shadow.n_by_cmd[CMD_SETPOS],
             shadow.n_by_cmd[CMD_CLEAR], shadow.n_by_cmd[CMD_READ], shadow.n_scrolls);
    $display("Compared %0d result beats over four colour settings; %0d mismatches.",
             shadow.n_checked, shadow.n_errors);
    if (shadow.n_errors == 0 && shadow.owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
